// ===== rtl/hmpg_pkg.sv =====
// Package for the key-value hash map: payload types, codes and hash constants.
package hmpg_pkg;

	localparam int NUM_BUCKETS_DEF = 32;
	localparam int WAYS_DEF        = 4;

	localparam int KEY_W   = 32;
	localparam int VALUE_W = 31;

	localparam logic OP_PUT = 1'b0;
	localparam logic OP_GET = 1'b1;

	localparam logic [1:0] ST_NEW     = 2'd0;
	localparam logic [1:0] ST_UPDATED = 2'd1;
	localparam logic [1:0] ST_FOUND   = 2'd2;
	localparam logic [1:0] ST_MISS    = 2'd3;

	// golden ratio fraction, 0x9E3779B97F4A7C15, split in halves
	localparam logic [31:0] GOLD_HI = 32'h9E3779B9;
	localparam logic [31:0] GOLD_LO = 32'h7F4A7C15;

	// mod 19 via byte residues, then reciprocal multiply with one correction
	localparam int DIV_MODULUS = 19;
	localparam int RAD1        = 256 % DIV_MODULUS;
	localparam int RAD2        = (RAD1 * 256) % DIV_MODULUS;
	localparam int RAD3        = (RAD2 * 256) % DIV_MODULUS;
	localparam int SUM_W       = 13;
	localparam int RECIP_SHIFT = 16;
	localparam int DIV_RECIP   = (1 << RECIP_SHIFT) / DIV_MODULUS;
	localparam int PROD_W      = 25;
	localparam int Q_W         = PROD_W - RECIP_SHIFT;
	localparam int REM_W       = $clog2(DIV_MODULUS);

	typedef struct packed {
		logic               opcode;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [VALUE_W-1:0] read_value;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} entry_t;

endpackage

// ===== rtl/hmpg_hash.sv =====
// Bucket index unit: three-stage pipeline for the division and golden ratio hashes.
module hmpg_hash #(
	parameter int NUM_BUCKETS = hmpg_pkg::NUM_BUCKETS_DEF,
	localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
	input  logic                         clk,
	input  logic [hmpg_pkg::KEY_W-1:0]   key,
	input  logic                         mode,
	output logic [BW-1:0]                bucket
);

	localparam int NW = $clog2(NUM_BUCKETS + 1);
	localparam int AW = 32 + NW;

	logic [hmpg_pkg::SUM_W-1:0]  dsum;
	logic [63:0]                 plo;
	logic [31:0]                 phi;
	logic [hmpg_pkg::PROD_W-1:0] qprod;
	logic [hmpg_pkg::SUM_W-1:0]  rem0;
	logic [AW-1:0]               ah;
	logic [AW-1:0]               al;
	logic [AW-1:0]               fsum;
	logic [BW-1:0]               mbucket;
	logic [BW-1:0]               mod_tab [hmpg_pkg::DIV_MODULUS];

	logic [hmpg_pkg::SUM_W-1:0]  dsum_s1;
	logic [63:0]                 plo_s1;
	logic [31:0]                 phi_s1;
	logic [hmpg_pkg::SUM_W-1:0]  dsum_s2;
	logic [hmpg_pkg::Q_W-1:0]    q_s2;
	logic [63:0]                 f_s2;
	logic [hmpg_pkg::REM_W-1:0]  rem_s3;
	logic [AW-1:0]               ah_s3;
	logic [NW-1:0]               al_s3;

	for (genvar i = 0; i < hmpg_pkg::DIV_MODULUS; i++) begin : g_mod
		assign mod_tab[i] = BW'(i % NUM_BUCKETS);
	end

	assign dsum = hmpg_pkg::SUM_W'(key[7:0])
		+ hmpg_pkg::SUM_W'(key[15:8]) * hmpg_pkg::SUM_W'(hmpg_pkg::RAD1)
		+ hmpg_pkg::SUM_W'(key[23:16]) * hmpg_pkg::SUM_W'(hmpg_pkg::RAD2)
		+ hmpg_pkg::SUM_W'(key[31:24]) * hmpg_pkg::SUM_W'(hmpg_pkg::RAD3);
	assign plo = {32'b0, key} * {32'b0, hmpg_pkg::GOLD_LO};
	assign phi = key * hmpg_pkg::GOLD_HI;

	assign qprod = hmpg_pkg::PROD_W'(dsum_s1) * hmpg_pkg::PROD_W'(hmpg_pkg::DIV_RECIP);

	// estimate is exact or one low
	assign rem0 = dsum_s2 - hmpg_pkg::SUM_W'(q_s2) * hmpg_pkg::SUM_W'(hmpg_pkg::DIV_MODULUS);
	assign ah = AW'(f_s2[63:32]) * AW'(NUM_BUCKETS);
	assign al = AW'(f_s2[31:0]) * AW'(NUM_BUCKETS);

	assign fsum = ah_s3 + AW'(al_s3);
	assign mbucket = BW'(fsum[AW-1:32]);
	assign bucket = mode ? mbucket : mod_tab[rem_s3];

	always_ff @(posedge clk) begin
		dsum_s1 <= dsum;
		plo_s1 <= plo;
		phi_s1 <= phi;

		dsum_s2 <= dsum_s1;
		q_s2 <= qprod[hmpg_pkg::PROD_W-1:hmpg_pkg::RECIP_SHIFT];
		f_s2 <= plo_s1 + {phi_s1, 32'b0};

		if (rem0 >= hmpg_pkg::SUM_W'(hmpg_pkg::DIV_MODULUS)) begin
			rem_s3 <= hmpg_pkg::REM_W'(rem0 - hmpg_pkg::SUM_W'(hmpg_pkg::DIV_MODULUS));
		end else begin
			rem_s3 <= hmpg_pkg::REM_W'(rem0);
		end
		ah_s3 <= ah;
		al_s3 <= al[AW-1:32];
	end

endmodule

// ===== rtl/hash_map_put_get.sv =====
// Top level of the key-value hash map with bounded buckets.
// A request passes the three-stage hash pipeline, a bucket row read and an update step
// that registers the result and waits while a held result is stalled; requests stall
// until the bucket row read-modify-write of the valid and entry memories is done.
// Reset: hash_mode clears to 0, then a pass over all NUM_BUCKETS rows clears the valid
// memory one row a cycle; requests stall during the pass, config writes are taken.
module hash_map_put_get #(
	parameter int NUM_BUCKETS = hmpg_pkg::NUM_BUCKETS_DEF,
	parameter int WAYS        = hmpg_pkg::WAYS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  hmpg_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output hmpg_pkg::rsp_t rsp,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic           cfg_data
);

	localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_H1,
		S_H2,
		S_H3,
		S_RD,
		S_UPD
	} state_t;

	state_t                          state_q;
	logic [BW-1:0]                   clr_cnt_q;
	logic                            hash_mode_q;
	logic                            rsp_valid_q;
	hmpg_pkg::rsp_t                  rsp_q;

	logic                            op_q;
	logic [hmpg_pkg::KEY_W-1:0]      key_q;
	logic [hmpg_pkg::VALUE_W-1:0]    value_q;
	logic [BW-1:0]                   bucket_q;
	logic [WAYS-1:0]                 vrd_q;
	hmpg_pkg::entry_t [WAYS-1:0]     drd_q;

	logic [WAYS-1:0]                 vmem [NUM_BUCKETS];
	hmpg_pkg::entry_t [WAYS-1:0]     dmem [NUM_BUCKETS];

	logic [BW-1:0]                   bucket;
	logic [WAYS-1:0]                 hit_vec;
	logic [WAYS-1:0]                 free_vec;
	logic [WAYS-1:0]                 hit_oh;
	logic [WAYS-1:0]                 free_oh;
	logic [WAYS-1:0]                 row_sel;
	logic                            hit;
	logic                            free_any;
	logic                            put_ok;
	logic                            rsp_free;
	logic                            upd_go;
	hmpg_pkg::entry_t [WAYS-1:0]     new_row;
	logic [hmpg_pkg::VALUE_W-1:0]    found_value;
	logic                            vwe;
	logic [BW-1:0]                   vwa;
	logic [WAYS-1:0]                 vwd;
	logic                            dwe;
	hmpg_pkg::rsp_t                  rsp_next;

	hmpg_hash #(
		.NUM_BUCKETS(NUM_BUCKETS)
	) u_hash (
		.clk    (clk),
		.key    (key_q),
		.mode   (hash_mode_q),
		.bucket (bucket)
	);

	assign req_stall = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			hit_vec[w] = vrd_q[w] && (drd_q[w].key == key_q);
		end
	end

	assign free_vec = ~vrd_q;
	assign hit_oh = hit_vec & (~hit_vec + WAYS'(1));
	assign free_oh = free_vec & (~free_vec + WAYS'(1));
	assign hit = |hit_vec;
	assign free_any = |free_vec;
	assign row_sel = hit ? hit_oh : free_oh;
	assign put_ok = (op_q == hmpg_pkg::OP_PUT) && (hit || free_any);
	assign rsp_free = !rsp_valid_q || !rsp_stall;
	assign upd_go = (state_q == S_UPD) && rsp_free;

	always_comb begin
		found_value = '0;
		for (int w = 0; w < WAYS; w++) begin
			new_row[w] = row_sel[w] ? hmpg_pkg::entry_t'{key: key_q, value: value_q} : drd_q[w];
			found_value = found_value | (drd_q[w].value & {hmpg_pkg::VALUE_W{hit_oh[w]}});
		end
	end

	always_comb begin
		rsp_next.status = hmpg_pkg::ST_MISS;
		rsp_next.read_value = '0;
		if (op_q == hmpg_pkg::OP_PUT) begin
			if (hit) begin
				rsp_next.status = hmpg_pkg::ST_UPDATED;
			end else if (free_any) begin
				rsp_next.status = hmpg_pkg::ST_NEW;
			end
		end else if (hit) begin
			rsp_next.status = hmpg_pkg::ST_FOUND;
			rsp_next.read_value = found_value;
		end
	end

	assign vwe = (state_q == S_CLEAR) || (upd_go && put_ok);
	assign vwa = (state_q == S_CLEAR) ? clr_cnt_q : bucket_q;
	assign vwd = (state_q == S_CLEAR) ? '0 : (vrd_q | row_sel);
	assign dwe = upd_go && put_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_mode_q <= 1'b0;
		end else if (cfg_valid) begin
			hash_mode_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_cnt_q <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			if (upd_go) begin
				rsp_valid_q <= 1'b1;
				rsp_q <= rsp_next;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= BW'(clr_cnt_q + 1'b1);
					if (clr_cnt_q == BW'(NUM_BUCKETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_H1;
					end
				end
				S_H1: state_q <= S_H2;
				S_H2: state_q <= S_H3;
				S_H3: state_q <= S_RD;
				S_RD: state_q <= S_UPD;
				S_UPD: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			op_q <= req.opcode;
			key_q <= req.key;
			value_q <= req.value;
		end
	end

	always_ff @(posedge clk) begin
		if (vwe) begin
			vmem[vwa] <= vwd;
		end
		if (dwe) begin
			dmem[bucket_q] <= new_row;
		end
		if (state_q == S_RD) begin
			bucket_q <= bucket;
			vrd_q <= vmem[bucket];
			drd_q <= dmem[bucket];
		end
	end

	a_accept_starts_hash: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == S_H1))
		else $error("request transfer did not start the hash pipeline");

	a_result_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == S_UPD))
		else $error("result raised outside the update step");

	a_value_only_on_found: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != hmpg_pkg::ST_FOUND) |-> (rsp.read_value == '0))
		else $error("nonzero read_value without a found status");

	a_update_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD && !rsp_free) |=> (state_q == S_UPD && $stable(bucket_q)))
		else $error("stalled update lost its bucket row");

endmodule
